FILE: rtl/dwg_pkg.sv
// Shared types, codes and reset values for the damped wave grid stencil core.
package dwg_pkg;

  localparam int GRID_MAX_DEF = 64;
  localparam int FRAC_BITS    = 28;
  localparam int VAL_W        = 32;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_COEF_SELF = 2'd1;
  localparam logic [1:0] CFG_COEF_PREV = 2'd2;
  localparam logic [1:0] CFG_COEF_LAP  = 2'd3;

  localparam logic [6:0]        GRID_SIZE_RST = 7'd64;
  localparam logic signed [31:0] COEF_SELF_RST = 32'sh2000_0000;
  localparam logic signed [31:0] COEF_PREV_RST = 32'shF000_0000;
  localparam logic signed [31:0] COEF_LAP_RST  = 32'sh0400_0000;

  // read capture tags
  localparam logic [2:0] TAG_NONE   = 3'd0;
  localparam logic [2:0] TAG_CENTER = 3'd1;
  localparam logic [2:0] TAG_UP     = 3'd2;
  localparam logic [2:0] TAG_DN     = 3'd3;
  localparam logic [2:0] TAG_LEFT   = 3'd4;
  localparam logic [2:0] TAG_RIGHT  = 3'd5;
  localparam logic [2:0] TAG_READ   = 3'd6;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_SELF  = 3'd1;
  localparam logic [2:0] MUL_PREV  = 3'd2;
  localparam logic [2:0] MUL_LAPLO = 3'd3;
  localparam logic [2:0] MUL_LAPHI = 3'd4;

  // write data sources
  localparam logic [1:0] SRC_CALC  = 2'd0;
  localparam logic [1:0] SRC_ZERO  = 2'd1;
  localparam logic [1:0] SRC_DRIVE = 2'd2;
  localparam logic [1:0] SRC_CELL  = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [5:0]         row;
    logic [5:0]         column;
    logic               grid_choice;
    logic signed [31:0] cell_value;
    logic signed [31:0] drive_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic       rd_en;
    logic [2:0] rd_tag;
    logic       rd_prev;
    logic       wr_en;
    logic       wr_all;
    logic       wr_prev;
    logic [1:0] wr_src;
    logic [2:0] mul_sel;
    logic       acc_clr;
    logic       lap_ld;
    logic       sat_upd;
    logic       flip;
    logic       item_ld;
    logic       out_ld;
  } dwg_cmd_t;

endpackage

FILE: rtl/damped_wave_grid_stencil_core.sv
// Top level of the damped wave grid stencil core: config registers, controller, datapath.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | dwg_pkg::in_item_t
//  out_    | output    | out_valid / out_stall| dwg_pkg::out_item_t
//  cfg_    | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// After reset both banks are zeroed by a pass over all GRID_MAX*GRID_MAX cells; no item is taken then.
// Write, unused opcode: DISPATCH then DONE; read: DISPATCH, RWAIT, DONE, which loads the result.
// Step: one shared multiplier and one read port per bank serve each cell of columns 1 to n-2
// in turn (n = active size), then the zero and drive border columns are written.
// A new item is taken while a result waits; a new result waits in DONE while out_valid is stalled.
module damped_wave_grid_stencil_core #(
  parameter int GRID_MAX = dwg_pkg::GRID_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dwg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dwg_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = $clog2(GRID_MAX * GRID_MAX);

  logic [6:0]         grid_size_r;
  logic signed [31:0] coef_self_r, coef_prev_r, coef_lap_r;

  dwg_pkg::dwg_cmd_t cmd;
  logic [AW-1:0]     rd_addr, wr_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= dwg_pkg::GRID_SIZE_RST;
      coef_self_r <= dwg_pkg::COEF_SELF_RST;
      coef_prev_r <= dwg_pkg::COEF_PREV_RST;
      coef_lap_r  <= dwg_pkg::COEF_LAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dwg_pkg::CFG_GRID_SIZE: grid_size_r <= cfg_wdata[6:0];
        dwg_pkg::CFG_COEF_SELF: coef_self_r <= cfg_wdata;
        dwg_pkg::CFG_COEF_PREV: coef_prev_r <= cfg_wdata;
        dwg_pkg::CFG_COEF_LAP:  coef_lap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dwg_ctrl #(.GRID_MAX(GRID_MAX)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .grid_size (grid_size_r),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr)
  );

  dwg_dp #(.GRID_MAX(GRID_MAX)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .in_data   (in_data),
    .coef_self (coef_self_r),
    .coef_prev (coef_prev_r),
    .coef_lap  (coef_lap_r),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/dwg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dwg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dwg_dp.sv
// Datapath: grid banks, stencil operand registers, shared multiplier, accumulator, output.
module dwg_dp #(
  parameter int GRID_MAX = dwg_pkg::GRID_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dwg_pkg::dwg_cmd_t                     cmd,
  input  logic [$clog2(GRID_MAX*GRID_MAX)-1:0]  rd_addr,
  input  logic [$clog2(GRID_MAX*GRID_MAX)-1:0]  wr_addr,
  input  dwg_pkg::in_item_t                     in_data,
  input  logic signed [31:0]                    coef_self,
  input  logic signed [31:0]                    coef_prev,
  input  logic signed [31:0]                    coef_lap,
  output dwg_pkg::out_item_t                    out_data
);

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int ACC_W = 72;
  localparam int LAP_W = 35;
  localparam int FRAC  = dwg_pkg::FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] QMAX = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] QMIN = ACC_W'(32'sh8000_0000);

  logic bank_sel_r;
  logic [2:0] tag_d_r;
  logic rprev_d_r;

  logic signed [31:0] cell_val_r, drive_r;
  logic signed [31:0] center_r, prv_r, up_r, dn_r, lf_r, rt_r;
  logic signed [LAP_W-1:0] lap_r;
  logic signed [64:0] prod_r;
  logic prod_vld_r, prod_shift_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] read_r;
  logic sat_r;
  dwg_pkg::out_item_t out_r;

  logic [31:0] rdata_a, rdata_b;
  logic signed [31:0] cur_data, nxt_data, pick_data;
  logic we_a, we_b;
  logic signed [31:0] wdata;

  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [ACC_W-1:0] p_ext, rnd_sum, quot, calc_val;
  logic clip;

  // logical grid to physical bank: bank b when bank_sel ^ prev is set
  assign we_a = cmd.wr_en && (cmd.wr_all || ((bank_sel_r ^ cmd.wr_prev) == 1'b0));
  assign we_b = cmd.wr_en && (cmd.wr_all || ((bank_sel_r ^ cmd.wr_prev) == 1'b1));

  dwg_ram #(.WIDTH(32), .DEPTH(CELLS)) u_bank_a (
    .clk(clk), .we(we_a), .waddr(wr_addr), .wdata(wdata),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata_r(rdata_a)
  );

  dwg_ram #(.WIDTH(32), .DEPTH(CELLS)) u_bank_b (
    .clk(clk), .we(we_b), .waddr(wr_addr), .wdata(wdata),
    .re(cmd.rd_en), .raddr(rd_addr), .rdata_r(rdata_b)
  );

  assign cur_data  = bank_sel_r ? rdata_b : rdata_a;
  assign nxt_data  = bank_sel_r ? rdata_a : rdata_b;
  assign pick_data = (bank_sel_r ^ rprev_d_r) ? rdata_b : rdata_a;

  always_comb begin
    p_ext = ACC_W'(prod_r);
    if (prod_shift_r) begin
      p_ext = p_ext <<< FRAC;
    end
    rnd_sum = acc_r + RND;
    quot    = rnd_sum >>> FRAC;
    clip    = 1'b0;
    calc_val = quot;
    if (quot > QMAX) begin
      calc_val = QMAX;
      clip     = 1'b1;
    end else if (quot < QMIN) begin
      calc_val = QMIN;
      clip     = 1'b1;
    end
  end

  always_comb begin
    case (cmd.wr_src)
      dwg_pkg::SRC_CALC:  wdata = calc_val[31:0];
      dwg_pkg::SRC_ZERO:  wdata = '0;
      dwg_pkg::SRC_DRIVE: wdata = drive_r;
      dwg_pkg::SRC_CELL:  wdata = cell_val_r;
      default:            wdata = '0;
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      dwg_pkg::MUL_SELF: begin
        mul_a = coef_self;
        mul_b = 33'(center_r);
      end
      dwg_pkg::MUL_PREV: begin
        mul_a = coef_prev;
        mul_b = 33'(prv_r);
      end
      dwg_pkg::MUL_LAPLO: begin
        mul_a = coef_lap;
        mul_b = {5'b0, lap_r[FRAC-1:0]};
      end
      dwg_pkg::MUL_LAPHI: begin
        mul_a = coef_lap;
        mul_b = 33'(signed'(lap_r[LAP_W-1:FRAC]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r   <= 1'b0;
      tag_d_r      <= dwg_pkg::TAG_NONE;
      prod_vld_r   <= 1'b0;
    end else begin
      if (cmd.flip) begin
        bank_sel_r <= ~bank_sel_r;
      end
      tag_d_r    <= cmd.rd_en ? cmd.rd_tag : dwg_pkg::TAG_NONE;
      prod_vld_r <= (cmd.mul_sel != dwg_pkg::MUL_NONE);
    end
  end

  always_ff @(posedge clk) begin
    rprev_d_r    <= cmd.rd_prev;
    prod_r       <= 65'(mul_a) * 65'(mul_b);
    prod_shift_r <= (cmd.mul_sel == dwg_pkg::MUL_LAPHI);
    if (cmd.item_ld) begin
      cell_val_r <= in_data.cell_value;
      drive_r    <= in_data.drive_value;
    end
    case (tag_d_r)
      dwg_pkg::TAG_CENTER: begin
        center_r <= cur_data;
        prv_r    <= nxt_data;
      end
      dwg_pkg::TAG_UP:    up_r <= cur_data;
      dwg_pkg::TAG_DN:    dn_r <= cur_data;
      dwg_pkg::TAG_LEFT:  lf_r <= cur_data;
      dwg_pkg::TAG_RIGHT: rt_r <= cur_data;
      default: ;
    endcase
    if (cmd.lap_ld) begin
      lap_r <= LAP_W'(up_r) + LAP_W'(dn_r) + LAP_W'(lf_r) + LAP_W'(rt_r)
             - (LAP_W'(center_r) <<< 2);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + p_ext;
    end
    if (cmd.item_ld) begin
      read_r <= '0;
      sat_r  <= 1'b0;
    end else begin
      if (tag_d_r == dwg_pkg::TAG_READ) begin
        read_r <= pick_data;
      end
      if (cmd.sat_upd && clip) begin
        sat_r <= 1'b1;
      end
    end
    if (cmd.out_ld) begin
      out_r.read_value <= read_r;
      out_r.saturated  <= sat_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/dwg_ctrl.sv
// Controller: clearing pass, item dispatch, stencil sweep sequencing and output handshake.
module dwg_ctrl #(
  parameter int GRID_MAX = dwg_pkg::GRID_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dwg_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [6:0]                            grid_size,
  output dwg_pkg::dwg_cmd_t                     cmd,
  output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]  rd_addr,
  output logic [$clog2(GRID_MAX*GRID_MAX)-1:0]  wr_addr
);

  localparam int CELLS = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int IW    = $clog2(GRID_MAX);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_RWAIT    = 3'd3;
  localparam logic [2:0] S_CELL     = 3'd4;
  localparam logic [2:0] S_BORDER   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  localparam logic [3:0] PH_LAST = 4'd11;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [3:0] ph_r, ph_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] op_r, op_nxt;
  logic [5:0] row_r, row_nxt, col_r, col_nxt;
  logic choice_r, choice_nxt;

  logic [8:0] gs9, n9, n_m1, n_m2;
  logic in_range;
  logic last_row, last_col;
  logic [IW-1:0] up_i, dn_i;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    cell_addr = AW'(AW'(r) * AW'(GRID_MAX) + AW'(c));
  endfunction

  always_comb begin
    gs9 = 9'(grid_size);
    if (gs9 < 9'd3) begin
      n9 = 9'd3;
    end else if (gs9 > 9'(GRID_MAX)) begin
      n9 = 9'(GRID_MAX);
    end else begin
      n9 = gs9;
    end
    n_m1 = n9 - 9'd1;
    n_m2 = n9 - 9'd2;
  end

  assign in_range = (9'(row_r) < 9'(GRID_MAX)) && (9'(col_r) < 9'(GRID_MAX));
  assign last_row = (9'(i_r) == n_m1);
  assign last_col = (9'(j_r) == n_m2);
  assign up_i     = (i_r == '0) ? IW'(1) : IW'(i_r - 1'b1);
  assign dn_i     = last_row ? IW'(n_m2) : IW'(i_r + 1'b1);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ph_nxt     = ph_r;
    op_nxt     = op_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    choice_nxt = choice_r;
    cmd        = '0;
    rd_addr    = '0;
    wr_addr    = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_all = 1'b1;
        cmd.wr_src = dwg_pkg::SRC_ZERO;
        wr_addr    = clr_r;
        clr_nxt    = AW'(clr_r + 1'b1);
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          op_nxt      = in_data.opcode;
          row_nxt     = in_data.row;
          col_nxt     = in_data.column;
          choice_nxt  = in_data.grid_choice;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_r)
          dwg_pkg::OP_WRITE: begin
            cmd.wr_en   = in_range;
            cmd.wr_prev = choice_r;
            cmd.wr_src  = dwg_pkg::SRC_CELL;
            wr_addr     = cell_addr(IW'(row_r), IW'(col_r));
            state_nxt   = S_DONE;
          end
          dwg_pkg::OP_READ: begin
            cmd.rd_en   = in_range;
            cmd.rd_tag  = dwg_pkg::TAG_READ;
            cmd.rd_prev = choice_r;
            rd_addr     = cell_addr(IW'(row_r), IW'(col_r));
            state_nxt   = S_RWAIT;
          end
          dwg_pkg::OP_STEP: begin
            i_nxt     = '0;
            j_nxt     = IW'(1);
            ph_nxt    = '0;
            state_nxt = S_CELL;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RWAIT: state_nxt = S_DONE;
      S_CELL: begin
        ph_nxt = 4'(ph_r + 1'b1);
        case (ph_r)
          4'd0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tag = dwg_pkg::TAG_CENTER;
            rd_addr    = cell_addr(i_r, j_r);
          end
          4'd1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tag = dwg_pkg::TAG_UP;
            rd_addr    = cell_addr(up_i, j_r);
          end
          4'd2: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tag = dwg_pkg::TAG_DN;
            rd_addr    = cell_addr(dn_i, j_r);
          end
          4'd3: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tag = dwg_pkg::TAG_LEFT;
            rd_addr    = cell_addr(i_r, IW'(j_r - 1'b1));
          end
          4'd4: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_tag = dwg_pkg::TAG_RIGHT;
            rd_addr    = cell_addr(i_r, IW'(j_r + 1'b1));
          end
          4'd6: begin
            cmd.lap_ld  = 1'b1;
            cmd.acc_clr = 1'b1;
            cmd.mul_sel = dwg_pkg::MUL_SELF;
          end
          4'd7: cmd.mul_sel = dwg_pkg::MUL_PREV;
          4'd8: cmd.mul_sel = dwg_pkg::MUL_LAPLO;
          4'd9: cmd.mul_sel = dwg_pkg::MUL_LAPHI;
          PH_LAST: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_prev = 1'b1;
            cmd.wr_src  = dwg_pkg::SRC_CALC;
            cmd.sat_upd = 1'b1;
            wr_addr     = cell_addr(i_r, j_r);
            ph_nxt      = '0;
            if (last_row) begin
              i_nxt = '0;
              if (last_col) begin
                state_nxt = S_BORDER;
              end else begin
                j_nxt = IW'(j_r + 1'b1);
              end
            end else begin
              i_nxt = IW'(i_r + 1'b1);
            end
          end
          default: ;
        endcase
      end
      S_BORDER: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_prev = 1'b1;
        ph_nxt      = {3'b0, ~ph_r[0]};
        if (!ph_r[0]) begin
          cmd.wr_src = dwg_pkg::SRC_ZERO;
          wr_addr    = cell_addr(i_r, '0);
        end else begin
          cmd.wr_src = dwg_pkg::SRC_DRIVE;
          wr_addr    = cell_addr(i_r, IW'(n_m1));
          i_nxt      = IW'(i_r + 1'b1);
          if (last_row) begin
            cmd.flip  = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    choice_r <= choice_nxt;
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DISPATCH)
    else $error("accepted transfer did not enter dispatch");

  a_sweep_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CELL |-> 9'(i_r) <= n_m1 && j_r != '0 && 9'(j_r) <= n_m2)
    else $error("stencil sweep index out of interior range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_valid_r)
    else $error("result load did not raise out_valid");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("out_valid rose outside done state");

endmodule
